// ----- rtl/esg_pkg.sv -----
// Shared constants and types of the energy silence gate.
package esg_pkg;

    // Longest frame that is measured; later samples of a frame are dropped.
    localparam int MAX_FRAME_SAMPLES = 1024;

    // Widths derived from the frame length and the sample format.
    localparam int SAMPLE_W = 16;
    localparam int SQ_W     = 31;
    localparam int CNT_W    = $clog2(MAX_FRAME_SAMPLES + 1);
    localparam int ENERGY_W = SQ_W - 1 + CNT_W;
    localparam int LEVEL_W  = 31;
    localparam int PROD_W   = LEVEL_W + CNT_W;
    localparam int HANG_W   = 8;
    localparam int SEQ_W    = 32;

    // APB port geometry.
    localparam int APB_AW = 3;
    localparam int APB_DW = 32;

    localparam logic [CNT_W-1:0]  MAX_CNT    = CNT_W'(MAX_FRAME_SAMPLES);
    localparam logic [HANG_W-1:0] HANG_RESET = HANG_W'(10);
    localparam logic [SEQ_W-1:0]  SEQ_RESET  = SEQ_W'(1);

    // Register index, taken from address bit 2.
    typedef enum logic {
        REG_LEVEL = 1'b0,
        REG_HANG  = 1'b1
    } t_reg_idx;

    // Configuration values seen by the datapath.
    typedef struct packed {
        logic [LEVEL_W-1:0] level;
        logic [HANG_W-1:0]  hang;
    } t_cfg;

    // Finished frame measurement handed to the decision stage.
    typedef struct packed {
        logic                valid;
        logic [ENERGY_W-1:0] energy;
        logic [PROD_W-1:0]   limit;
    } t_meas;

endpackage

// ----- rtl/esg_if.sv -----
// Valid/ready channel interfaces for samples and frame results.
interface esg_sample_if
    import esg_pkg::*;
;
    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] sample;
    logic                       frame_end;

    modport source (output valid, output sample, output frame_end, input ready);
    modport sink (input valid, input sample, input frame_end, output ready);
endinterface

interface esg_result_if
    import esg_pkg::*;
;
    logic              valid;
    logic              ready;
    logic              send_frame;
    logic              frame_silent;
    logic [SEQ_W-1:0]  sequence_number;
    logic [HANG_W-1:0] hangover_left;

    modport source (output valid, output send_frame, output frame_silent,
                    output sequence_number, output hangover_left, input ready);
    modport sink (input valid, input send_frame, input frame_silent,
                  input sequence_number, input hangover_left, output ready);
endinterface

// ----- rtl/esg_cfg.sv -----
// APB register block holding the silence threshold and hangover length.
module esg_cfg
    import esg_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready,
    output t_cfg              o_cfg
);

    logic [LEVEL_W-1:0] r_level;
    logic [HANG_W-1:0]  r_hang;
    logic               wr_en;
    t_reg_idx           reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite;
    assign reg_idx = t_reg_idx'(paddr[2]);

    // Register writes in the access phase.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_level <= '0;
            r_hang  <= HANG_RESET;
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_LEVEL: r_level <= pwdata[LEVEL_W-1:0];
                REG_HANG:  r_hang  <= pwdata[HANG_W-1:0];
                default: ;
            endcase
        end
    end

    // Read data mux.
    always_comb begin
        unique case (reg_idx)
            REG_LEVEL: prdata = APB_DW'(r_level);
            REG_HANG:  prdata = APB_DW'(r_hang);
            default:   prdata = '0;
        endcase
    end

    assign o_cfg.level = r_level;
    assign o_cfg.hang  = r_hang;

endmodule

// ----- rtl/esg_energy.sv -----
// Sample pipeline: square, accumulate per frame, and scale the threshold.
module esg_energy
    import esg_pkg::*;
(
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_en,
    input  logic                       i_take,
    input  logic signed [SAMPLE_W-1:0] i_sample,
    input  logic                       i_frame_end,
    input  logic [LEVEL_W-1:0]         i_level,
    output t_meas                      o_meas
);

    // Stage 1: input register.
    logic                       r1_v;
    logic signed [SAMPLE_W-1:0] r1_sample;
    logic                       r1_last;

    // Stage 2: squared sample.
    logic                       r2_v;
    logic [SQ_W-1:0]            r2_sq;
    logic                       r2_last;

    // Stage 3: frame accumulators and the closed frame.
    logic [ENERGY_W-1:0]        r_energy;
    logic [CNT_W-1:0]           r_count;
    logic                       r3_v;
    logic [ENERGY_W-1:0]        r3_energy;
    logic [CNT_W-1:0]           r3_count;

    // Stage 4: energy with its threshold limit.
    logic                       r4_v;
    logic [ENERGY_W-1:0]        r4_energy;
    logic [PROD_W-1:0]          r4_limit;

    logic signed [2*SAMPLE_W-1:0] sq_full;
    logic                         room;
    logic [ENERGY_W-1:0]          n_energy;
    logic [CNT_W-1:0]             n_count;

    assign sq_full = r1_sample * r1_sample;

    // Samples past the frame length limit are neither counted nor added.
    assign room     = (r_count < MAX_CNT);
    assign n_energy = room ? r_energy + ENERGY_W'(r2_sq) : r_energy;
    assign n_count  = room ? r_count + CNT_W'(1) : r_count;

    // Control state of the pipeline.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v     <= 1'b0;
            r2_v     <= 1'b0;
            r3_v     <= 1'b0;
            r4_v     <= 1'b0;
            r_energy <= '0;
            r_count  <= '0;
        end else if (i_en) begin
            r1_v <= i_take;
            r2_v <= r1_v;
            r3_v <= r2_v & r2_last;
            r4_v <= r3_v;
            if (r2_v) begin
                if (r2_last) begin
                    r_energy <= '0;
                    r_count  <= '0;
                end else begin
                    r_energy <= n_energy;
                    r_count  <= n_count;
                end
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_sample <= i_sample;
            r1_last   <= i_frame_end;
            r2_sq     <= sq_full[SQ_W-1:0];
            r2_last   <= r1_last;
            r3_energy <= n_energy;
            r3_count  <= n_count;
            r4_energy <= r3_energy;
            r4_limit  <= PROD_W'(i_level) * PROD_W'(r3_count);
        end
    end

    assign o_meas.valid  = r4_v;
    assign o_meas.energy = r4_energy;
    assign o_meas.limit  = r4_limit;

endmodule

// ----- rtl/energy_silence_gate_with_hangover_top.sv -----
// Energy silence gate with hangover: top level with the frame decision.
// Samples are taken one per cycle. The energy of each frame is the sum of
// squared samples; at the frame end it is compared with the threshold times
// the sample count, and loud frames plus a hangover of silent frames are
// passed with a running sequence number. A frame-end sample passes through
// the input register, the squarer, the accumulator, the threshold multiplier
// and the decision stage, which writes the result into the output register.
// The pipeline sustains one sample per cycle; it holds only when a second
// result reaches the decision stage while the output register still waits to
// be taken.
module energy_silence_gate_with_hangover_top
    import esg_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    esg_sample_if.sink        i_samp,
    esg_result_if.source      o_res,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready
);

    t_cfg              cfg;
    t_meas             meas;
    logic              en;
    logic              take;

    logic              silent;
    logic              send;
    logic [HANG_W-1:0] n_hang;

    logic [HANG_W-1:0] r_hang;
    logic [SEQ_W-1:0]  r_next_seq;
    logic              r_out_v;
    logic              r_out_send;
    logic              r_out_silent;
    logic [SEQ_W-1:0]  r_out_seq;
    logic [HANG_W-1:0] r_out_hang;

    esg_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // The pipeline moves unless a result is blocked by a full output register.
    assign en   = ~(meas.valid & r_out_v & ~o_res.ready);
    assign take = i_samp.valid & en;
    assign i_samp.ready = en;

    esg_energy u_energy (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (en),
        .i_take      (take),
        .i_sample    (i_samp.sample),
        .i_frame_end (i_samp.frame_end),
        .i_level     (cfg.level),
        .o_meas      (meas)
    );

    // Frame decision and hangover update.
    always_comb begin
        silent = ({{(PROD_W-ENERGY_W){1'b0}}, meas.energy} <= meas.limit);
        if (!silent) begin
            n_hang = cfg.hang;
            send   = 1'b1;
        end else if (r_hang != '0) begin
            n_hang = r_hang - HANG_W'(1);
            send   = 1'b1;
        end else begin
            n_hang = r_hang;
            send   = 1'b0;
        end
    end

    // Gate state and output valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hang     <= '0;
            r_next_seq <= SEQ_RESET;
            r_out_v    <= 1'b0;
        end else begin
            if (en && meas.valid) begin
                r_hang  <= n_hang;
                r_out_v <= 1'b1;
                if (send) begin
                    r_next_seq <= r_next_seq + SEQ_W'(1);
                end
            end else if (o_res.ready) begin
                r_out_v <= 1'b0;
            end
        end
    end

    // Result payload.
    always_ff @(posedge i_clk) begin
        if (en && meas.valid) begin
            r_out_send   <= send;
            r_out_silent <= silent;
            r_out_seq    <= send ? r_next_seq : '0;
            r_out_hang   <= n_hang;
        end
    end

    assign o_res.valid           = r_out_v;
    assign o_res.send_frame      = r_out_send;
    assign o_res.frame_silent    = r_out_silent;
    assign o_res.sequence_number = r_out_seq;
    assign o_res.hangover_left   = r_out_hang;

    // A sent frame advances the sequence number by one.
    a_seq_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (en && meas.valid && send) |=> (r_next_seq == $past(r_next_seq) + SEQ_W'(1)))
        else $error("sequence number did not advance after a sent frame");

    // A loud frame reloads the hangover counter from the register.
    a_hang_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (en && meas.valid && !silent) |=> (r_hang == $past(cfg.hang)))
        else $error("loud frame did not reload the hangover counter");

    // A loud frame is always sent.
    a_loud_sent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_v && !r_out_silent) |-> r_out_send)
        else $error("loud frame reported as not sent");

    // A dropped frame carries sequence number zero.
    a_drop_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_v && !r_out_send) |-> (r_out_seq == '0))
        else $error("dropped frame carries a sequence number");

endmodule
